@@ rtl/csd_pkg.sv @@
// Shared types and constants for the capsule signed distance pipeline.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package csd_pkg;

    localparam int SQW    = 66;   // squared distances and dot products, magnitude
    localparam int TFRAC  = 30;   // fraction bits of the projection parameter
    localparam int ROOTW  = 33;   // floor square root of a SQW-bit value
    localparam int QW     = 25;   // quotient bits of the scaling divider
    localparam int NW     = 57;   // scaling numerator width
    localparam int NLANE  = 6;    // three gradient lanes, three surface lanes

    localparam logic [15:0] ONE_Q14 = 16'd16384;
    localparam logic [13:0] TINY_K  = 14'd9999;

    localparam logic signed [31:0] RST_START_Z = -32'sd12800;
    localparam logic signed [31:0] RST_END_Z   = 32'sd12800;
    localparam logic [23:0]        RST_RADIUS  = 24'd6400;

    typedef enum logic [2:0] {
        REG_START_X,
        REG_START_Y,
        REG_START_Z,
        REG_END_X,
        REG_END_Y,
        REG_END_Z,
        REG_RADIUS
    } t_reg_idx;

    typedef enum logic [1:0] {
        T_ZERO,
        T_ONE,
        T_DIV
    } t_tmode;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] signed_dist;
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic signed [15:0] grad_z;
        logic signed [31:0] surf_x;
        logic signed [31:0] surf_y;
        logic signed [31:0] surf_z;
        logic signed [15:0] surf_norm_x;
        logic signed [15:0] surf_norm_y;
        logic signed [15:0] surf_norm_z;
        logic               is_inside;
        logic               on_axis;
    } t_out;

    // carried alongside the projection divider
    typedef struct packed {
        logic [2:0][31:0] p;
        t_tmode           mode;
        logic             tiny;
        logic [SQW-1:0]   csum;
    } t_fd_sb;

    // carried alongside the square root
    typedef struct packed {
        logic [2:0][31:0] c;
        logic [2:0][32:0] comp;
        logic             axis;
        logic             in_cap;
    } t_sq_sb;

    // carried alongside the scaling divider
    typedef struct packed {
        logic [2:0][31:0] c;
        logic [2:0]       neg;
        logic             axis;
        logic             in_cap;
    } t_sd_sb;

endpackage

`default_nettype wire

@@ rtl/csd_frac_div.sv @@
// Pipelined restoring divider for the projection parameter, one quotient bit per stage.
// Depends on csd_pkg.
`default_nettype none

module csd_frac_div
    import csd_pkg::*;
#(
    parameter int SBW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [SQW-1:0]   i_rem,
    input  logic [SQW-1:0]   i_dd,
    input  logic [SBW-1:0]   i_sb,
    output logic             o_valid,
    output logic [TFRAC-1:0] o_q,
    output logic [SBW-1:0]   o_sb
);

    logic [TFRAC-1:0] r_v;
    logic [SQW-1:0]   r_rem [TFRAC];
    logic [SQW-1:0]   r_dd  [TFRAC];
    logic [TFRAC-1:0] r_q   [TFRAC];
    logic [SBW-1:0]   r_sb  [TFRAC];
    logic [SQW:0]     c_st  [TFRAC];

    // remainder stays below the divisor, so the doubled value fits one extra bit
    function automatic logic [SQW:0] fd_step(input logic [SQW-1:0] rem,
                                             input logic [SQW-1:0] dd);
        logic [SQW:0] sh;
        sh = {rem, 1'b0};
        if (sh >= {1'b0, dd}) begin
            fd_step = {1'b1, SQW'(sh - {1'b0, dd})};
        end else begin
            fd_step = {1'b0, sh[SQW-1:0]};
        end
    endfunction

    always_comb begin
        c_st[0] = fd_step(i_rem, i_dd);
        for (int k = 1; k < TFRAC; k++) begin
            c_st[k] = fd_step(r_rem[k-1], r_dd[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[TFRAC-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= c_st[0][SQW-1:0];
            r_dd[0]  <= i_dd;
            r_q[0]   <= {{(TFRAC-1){1'b0}}, c_st[0][SQW]};
            r_sb[0]  <= i_sb;
            for (int k = 1; k < TFRAC; k++) begin
                r_rem[k] <= c_st[k][SQW-1:0];
                r_dd[k]  <= r_dd[k-1];
                r_q[k]   <= {r_q[k-1][TFRAC-2:0], c_st[k][SQW]};
                r_sb[k]  <= r_sb[k-1];
            end
        end
    end

    assign o_valid = r_v[TFRAC-1];
    assign o_q     = r_q[TFRAC-1];
    assign o_sb    = r_sb[TFRAC-1];

endmodule

`default_nettype wire

@@ rtl/csd_isqrt.sv @@
// Pipelined floor square root, one result bit per stage.
// Depends on csd_pkg.
`default_nettype none

module csd_isqrt
    import csd_pkg::*;
#(
    parameter int SBW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [SQW-1:0]   i_rad,
    input  logic [SBW-1:0]   i_sb,
    output logic             o_valid,
    output logic [ROOTW-1:0] o_root,
    output logic [SBW-1:0]   o_sb
);

    logic [ROOTW-1:0] r_v;
    logic [SQW-1:0]   r_x   [ROOTW];
    logic [SQW-1:0]   r_res [ROOTW];
    logic [SBW-1:0]   r_sb  [ROOTW];
    logic [2*SQW-1:0] c_st  [ROOTW];

    // returns {remaining radicand, partial root}
    function automatic logic [2*SQW-1:0] sq_step(input logic [SQW-1:0] x,
                                                 input logic [SQW-1:0] res,
                                                 input int b);
        logic [SQW:0] one;
        logic [SQW:0] trial;
        one   = (SQW+1)'(1) << (2 * b);
        trial = {1'b0, res} + one;
        if ({1'b0, x} >= trial) begin
            sq_step = {SQW'({1'b0, x} - trial), SQW'(({1'b0, res} >> 1) + one)};
        end else begin
            sq_step = {x, res >> 1};
        end
    endfunction

    always_comb begin
        c_st[0] = sq_step(i_rad, '0, ROOTW - 1);
        for (int k = 1; k < ROOTW; k++) begin
            c_st[k] = sq_step(r_x[k-1], r_res[k-1], ROOTW - 1 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ROOTW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= c_st[0][2*SQW-1:SQW];
            r_res[0] <= c_st[0][SQW-1:0];
            r_sb[0]  <= i_sb;
            for (int k = 1; k < ROOTW; k++) begin
                r_x[k]   <= c_st[k][2*SQW-1:SQW];
                r_res[k] <= c_st[k][SQW-1:0];
                r_sb[k]  <= r_sb[k-1];
            end
        end
    end

    assign o_valid = r_v[ROOTW-1];
    assign o_root  = r_res[ROOTW-1][ROOTW-1:0];
    assign o_sb    = r_sb[ROOTW-1];

endmodule

`default_nettype wire

@@ rtl/csd_scale_div.sv @@
// Pipelined integer divider for the gradient and surface scaling, six lanes over one divisor.
// Depends on csd_pkg.
`default_nettype none

module csd_scale_div
    import csd_pkg::*;
#(
    parameter int SBW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NW-1:0]    i_num [NLANE],
    input  logic [ROOTW-1:0] i_s,
    input  logic [SBW-1:0]   i_sb,
    output logic             o_valid,
    output logic [QW-1:0]    o_q [NLANE],
    output logic [ROOTW-1:0] o_s,
    output logic [SBW-1:0]   o_sb
);

    logic [QW-1:0]    r_v;
    logic [NW-1:0]    r_rem [QW][NLANE];
    logic [QW-1:0]    r_q   [QW][NLANE];
    logic [ROOTW-1:0] r_s   [QW];
    logic [SBW-1:0]   r_sb  [QW];
    logic [NW:0]      c_st  [QW][NLANE];

    // numerator is below s * 2^QW, so each step settles one quotient bit
    function automatic logic [NW:0] sd_step(input logic [NW-1:0] rem,
                                            input logic [ROOTW-1:0] s,
                                            input int b);
        logic [NW:0] dv;
        dv = (NW+1)'(s) << b;
        if ({1'b0, rem} >= dv) begin
            sd_step = {1'b1, NW'({1'b0, rem} - dv)};
        end else begin
            sd_step = {1'b0, rem};
        end
    endfunction

    always_comb begin
        for (int j = 0; j < NLANE; j++) begin
            c_st[0][j] = sd_step(i_num[j], i_s, QW - 1);
            for (int k = 1; k < QW; k++) begin
                c_st[k][j] = sd_step(r_rem[k-1][j], r_s[k-1], QW - 1 - k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0]  <= i_s;
            r_sb[0] <= i_sb;
            for (int j = 0; j < NLANE; j++) begin
                r_rem[0][j] <= c_st[0][j][NW-1:0];
                r_q[0][j]   <= {{(QW-1){1'b0}}, c_st[0][j][NW]};
            end
            for (int k = 1; k < QW; k++) begin
                r_s[k]  <= r_s[k-1];
                r_sb[k] <= r_sb[k-1];
                for (int j = 0; j < NLANE; j++) begin
                    r_rem[k][j] <= c_st[k][j][NW-1:0];
                    r_q[k][j]   <= {r_q[k-1][j][QW-2:0], c_st[k][j][NW]};
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NLANE; j++) begin
            o_q[j] = r_q[QW-1][j];
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_s     = r_s[QW-1];
    assign o_sb    = r_sb[QW-1];

endmodule

`default_nettype wire

@@ rtl/capsule_signed_distance.sv @@
// Top level: point against capsule signed distance, fully pipelined.
// Depends on csd_pkg, csd_frac_div, csd_isqrt and csd_scale_div.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   point   | in        | i_valid / o_stall   | i_data (t_in)
//   result  | out       | o_valid / i_stall   | o_data (t_out)
//   config  | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// One point enters per cycle while no finished result is held back; each point gives one result.
// The pipeline is made of the 30-stage projection divider, the 33-stage square root
// and the 25-stage scaling divider, plus 12 arithmetic stages.
// Reset is synchronous, active low; it empties the pipeline and loads the default capsule.
// A stalled result holds the whole pipeline, the point channel included; points are
// taken in every cycle in which no finished result is held back.
`default_nettype none

module capsule_signed_distance
    import csd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic en;

    // capsule registers
    logic signed [31:0] r_cs [3];
    logic signed [31:0] r_ce [3];
    logic [23:0]        r_rad;

    logic signed [32:0] c_d    [3];
    logic               c_dneg [3];
    logic [31:0]        c_dmag [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs[0] <= '0;
            r_cs[1] <= '0;
            r_cs[2] <= RST_START_Z;
            r_ce[0] <= '0;
            r_ce[1] <= '0;
            r_ce[2] <= RST_END_Z;
            r_rad   <= RST_RADIUS;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_START_X: r_cs[0] <= i_cfg_data;
                REG_START_Y: r_cs[1] <= i_cfg_data;
                REG_START_Z: r_cs[2] <= i_cfg_data;
                REG_END_X:   r_ce[0] <= i_cfg_data;
                REG_END_Y:   r_ce[1] <= i_cfg_data;
                REG_END_Z:   r_ce[2] <= i_cfg_data;
                REG_RADIUS:  r_rad   <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // axis direction; the user must change the registers only while the pipeline is empty (not enforced here)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_d[i]    = $signed({r_ce[i][31], r_ce[i]}) - $signed({r_cs[i][31], r_cs[i]});
            c_dneg[i] = c_d[i][32];
            c_dmag[i] = c_dneg[i] ? 32'(-c_d[i]) : c_d[i][31:0];
        end
    end

    // ---------------------------------------------------------------- S1: input register
    logic               r1_v;
    logic signed [31:0] r1_p [3];

    // ---------------------------------------------------------------- S2: differences
    logic               r2_v;
    logic signed [32:0] r2_vv [3];
    logic signed [32:0] r2_d  [3];
    logic signed [31:0] r2_p  [3];

    // ---------------------------------------------------------------- S3: products
    logic               r3_v;
    logic signed [65:0] r3_pdv [3];
    logic [63:0]        r3_dsq [3];
    logic signed [31:0] r3_p   [3];
    logic signed [65:0] c3_sq  [3];

    // ---------------------------------------------------------------- S4: sums
    logic               r4_v;
    logic signed [66:0] r4_dot;
    logic [SQW-1:0]     r4_dd;
    logic [64:0]        r4_h;
    logic [63:0]        r4_dx2;
    logic [63:0]        r4_dz2;
    logic signed [31:0] r4_p [3];

    // ---------------------------------------------------------------- S5: divider setup
    logic               r5_v;
    logic [SQW-1:0]     r5_rem;
    logic [SQW-1:0]     r5_dd;
    t_fd_sb             r5_sb;
    t_tmode             c5_mode;
    logic [78:0]        c5_hk;
    logic               c5_tiny;

    logic               fd_v;
    logic [TFRAC-1:0]   fd_q;
    t_fd_sb             fd_sb;

    // ---------------------------------------------------------------- S6..S10
    logic               r6_v;
    logic [TFRAC:0]     r6_t;
    t_fd_sb             r6_sb;
    logic [TFRAC:0]     c6_t;

    logic               r7_v;
    logic [31:0]        r7_off [3];
    t_fd_sb             r7_sb;
    logic [62:0]        c7_prod [3];

    logic               r8_v;
    logic signed [31:0] r8_c [3];
    logic signed [32:0] r8_w [3];
    logic               r8_tiny;
    logic [SQW-1:0]     r8_csum;
    logic signed [33:0] c8_off [3];
    logic signed [33:0] c8_c   [3];

    logic               r9_v;
    logic [63:0]        r9_wsq [3];
    logic [47:0]        r9_rr;
    logic signed [31:0] r9_c [3];
    logic signed [32:0] r9_w [3];
    logic               r9_tiny;
    logic [SQW-1:0]     r9_csum;
    logic signed [65:0] c9_sq [3];

    logic               r10_v;
    logic [SQW-1:0]     r10_rad;
    t_sq_sb             r10_sb;
    logic [SQW-1:0]     c10_dist2;
    logic               c10_axis;
    logic signed [32:0] c10_cv [3];
    t_sq_sb             c10_sb;

    logic               sq_v;
    logic [ROOTW-1:0]   sq_root;
    t_sq_sb             sq_sb;

    // ---------------------------------------------------------------- S11: numerators
    logic               r11_v;
    logic [NW-1:0]      r11_num [NLANE];
    logic [ROOTW-1:0]   r11_s;
    t_sd_sb             r11_sb;
    logic [31:0]        c11_mag [3];
    logic [NW-1:0]      c11_num [NLANE];
    t_sd_sb             c11_sb;

    logic               sd_v;
    logic [QW-1:0]      sd_q [NLANE];
    logic [ROOTW-1:0]   sd_s;
    t_sd_sb             sd_sb;

    // ---------------------------------------------------------------- S12: output
    logic               r_ov;
    t_out               r_out;
    logic [15:0]        c12_gm   [3];
    logic [15:0]        c12_grad [3];
    logic [23:0]        c12_sm   [3];
    logic signed [33:0] c12_add  [3];
    logic [31:0]        c12_surf [3];
    logic signed [34:0] c12_sdr;
    logic [31:0]        c12_sdist;
    t_out               c12_out;

    function automatic logic [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            sat34 = 32'h7fff_ffff;
        end else if (v < -34'sd2147483648) begin
            sat34 = 32'h8000_0000;
        end else begin
            sat34 = v[31:0];
        end
    endfunction

    // the whole pipeline advances unless a finished result is held back
    assign en      = !(r_ov && i_stall);
    assign o_stall = !en;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r1_v  <= i_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_v  <= fd_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= sq_v;
            r_ov  <= sd_v;
        end
    end

    // front end: differences, products, sums
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c3_sq[i] = r2_d[i] * r2_d[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p[0] <= i_data.point_x;
            r1_p[1] <= i_data.point_y;
            r1_p[2] <= i_data.point_z;
            for (int i = 0; i < 3; i++) begin
                r2_vv[i]  <= $signed({r1_p[i][31], r1_p[i]}) - $signed({r_cs[i][31], r_cs[i]});
                r2_d[i]   <= c_d[i];
                r2_p[i]   <= r1_p[i];
                r3_pdv[i] <= r2_d[i] * r2_vv[i];
                r3_dsq[i] <= c3_sq[i][63:0];
                r3_p[i]   <= r2_p[i];
                r4_p[i]   <= r3_p[i];
            end
            r4_dot <= 67'(r3_pdv[0]) + 67'(r3_pdv[1]) + 67'(r3_pdv[2]);
            r4_dd  <= SQW'(r3_dsq[0]) + SQW'(r3_dsq[1]) + SQW'(r3_dsq[2]);
            r4_h   <= 65'(r3_dsq[0]) + 65'(r3_dsq[1]);
            r4_dx2 <= r3_dsq[0];
            r4_dz2 <= r3_dsq[2];
        end
    end

    // clamp the projection and pick the fallback direction for on-axis points
    always_comb begin
        if (r4_dot <= 67'sd0) begin
            c5_mode = T_ZERO;
        end else if (r4_dot >= $signed({1'b0, r4_dd})) begin
            c5_mode = T_ONE;
        end else begin
            c5_mode = T_DIV;
        end
        c5_hk   = 79'(r4_h) * 79'(TINY_K);
        c5_tiny = c5_hk < 79'(r4_dz2);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_rem        <= r4_dot[SQW-1:0];
            r5_dd         <= r4_dd;
            r5_sb.p[0]    <= r4_p[0];
            r5_sb.p[1]    <= r4_p[1];
            r5_sb.p[2]    <= r4_p[2];
            r5_sb.mode    <= c5_mode;
            r5_sb.tiny    <= c5_tiny;
            r5_sb.csum    <= c5_tiny ? SQW'(r4_dx2) + SQW'(r4_dz2) : SQW'(r4_h);
        end
    end

    csd_frac_div #(
        .SBW ($bits(t_fd_sb))
    ) u_frac_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_rem   (r5_rem),
        .i_dd    (r5_dd),
        .i_sb    (r5_sb),
        .o_valid (fd_v),
        .o_q     (fd_q),
        .o_sb    (fd_sb)
    );

    // axis point, offset and squared distance
    always_comb begin
        case (fd_sb.mode)
            T_ZERO:  c6_t = '0;
            T_ONE:   c6_t = (TFRAC+1)'(1) << TFRAC;
            T_DIV:   c6_t = {1'b0, fd_q};
            default: c6_t = '0;
        endcase
        for (int i = 0; i < 3; i++) begin
            c7_prod[i] = 63'(c_dmag[i]) * 63'(r6_t) + (63'(1) << (TFRAC - 1));
            c8_off[i]  = c_dneg[i] ? -$signed({2'b00, r7_off[i]}) : $signed({2'b00, r7_off[i]});
            c8_c[i]    = $signed({{2{r_cs[i][31]}}, r_cs[i]}) + c8_off[i];
            c9_sq[i]   = r8_w[i] * r8_w[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_t  <= c6_t;
            r6_sb <= fd_sb;
            r7_sb <= r6_sb;
            for (int i = 0; i < 3; i++) begin
                r7_off[i] <= c7_prod[i][TFRAC+31:TFRAC];
                r8_c[i]   <= c8_c[i][31:0];
                r8_w[i]   <= $signed({r7_sb.p[i][31], r7_sb.p[i]})
                             - $signed({c8_c[i][31], c8_c[i][31:0]});
                r9_wsq[i] <= c9_sq[i][63:0];
                r9_c[i]   <= r8_c[i];
                r9_w[i]   <= r8_w[i];
            end
            r8_tiny <= r7_sb.tiny;
            r8_csum <= r7_sb.csum;
            r9_rr   <= 48'(r_rad) * 48'(r_rad);
            r9_tiny <= r8_tiny;
            r9_csum <= r8_csum;
        end
    end

    // on the axis, measure the fallback direction instead of the offset
    always_comb begin
        c10_dist2 = SQW'(r9_wsq[0]) + SQW'(r9_wsq[1]) + SQW'(r9_wsq[2]);
        c10_axis  = (c10_dist2 == '0);
        if (r9_tiny) begin
            c10_cv[0] = -c_d[2];
            c10_cv[1] = '0;
            c10_cv[2] = c_d[0];
        end else begin
            c10_cv[0] = c_d[1];
            c10_cv[1] = -c_d[0];
            c10_cv[2] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            c10_sb.c[i]    = r9_c[i];
            c10_sb.comp[i] = c10_axis ? c10_cv[i] : r9_w[i];
        end
        c10_sb.axis   = c10_axis;
        c10_sb.in_cap = c10_dist2 <= SQW'(r9_rr);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_rad <= c10_axis ? r9_csum : c10_dist2;
            r10_sb  <= c10_sb;
        end
    end

    csd_isqrt #(
        .SBW ($bits(t_sq_sb))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r10_v),
        .i_rad   (r10_rad),
        .i_sb    (r10_sb),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_sb    (sq_sb)
    );

    // numerators with round-half-up bias; lanes 0..2 gradient, 3..5 surface
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c11_mag[i]     = sq_sb.comp[i][32] ? 32'(-$signed(sq_sb.comp[i]))
                                               : sq_sb.comp[i][31:0];
            c11_num[i]     = (NW'(c11_mag[i]) << 14) + NW'(sq_root >> 1);
            c11_num[3 + i] = NW'(c11_mag[i]) * NW'(r_rad) + NW'(sq_root >> 1);
            c11_sb.c[i]    = sq_sb.c[i];
            c11_sb.neg[i]  = sq_sb.comp[i][32];
        end
        c11_sb.axis   = sq_sb.axis;
        c11_sb.in_cap = sq_sb.in_cap;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < NLANE; j++) begin
                r11_num[j] <= c11_num[j];
            end
            r11_s  <= sq_root;
            r11_sb <= c11_sb;
        end
    end

    csd_scale_div #(
        .SBW ($bits(t_sd_sb))
    ) u_scale_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r11_v),
        .i_num   (r11_num),
        .i_s     (r11_s),
        .i_sb    (r11_sb),
        .o_valid (sd_v),
        .o_q     (sd_q),
        .o_s     (sd_s),
        .o_sb    (sd_sb)
    );

    // clamp, apply signs, saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c12_gm[i]   = (sd_q[i] > QW'(ONE_Q14)) ? ONE_Q14 : sd_q[i][15:0];
            c12_grad[i] = (sd_s == '0) ? '0 : (sd_sb.neg[i] ? 16'(-c12_gm[i]) : c12_gm[i]);
            c12_sm[i]   = (sd_q[3 + i] > QW'(r_rad)) ? r_rad : sd_q[3 + i][23:0];
            if (sd_sb.axis) begin
                c12_add[i] = (i == 2) ? $signed({10'b0, r_rad}) : 34'sd0;
            end else begin
                c12_add[i] = sd_sb.neg[i] ? -$signed({10'b0, c12_sm[i]})
                                          : $signed({10'b0, c12_sm[i]});
            end
            c12_surf[i] = sat34($signed({{2{sd_sb.c[i][31]}}, sd_sb.c[i]}) + c12_add[i]);
        end
        c12_sdr = $signed({2'b00, sd_s}) - $signed({11'b0, r_rad});
        if (sd_sb.axis) begin
            c12_sdist = 32'd0 - {8'b0, r_rad};
        end else if (c12_sdr > 35'sd2147483647) begin
            c12_sdist = 32'h7fff_ffff;
        end else begin
            c12_sdist = c12_sdr[31:0];
        end
        c12_out.signed_dist = c12_sdist;
        c12_out.grad_x      = c12_grad[0];
        c12_out.grad_y      = c12_grad[1];
        c12_out.grad_z      = c12_grad[2];
        c12_out.surf_x      = c12_surf[0];
        c12_out.surf_y      = c12_surf[1];
        c12_out.surf_z      = c12_surf[2];
        c12_out.surf_norm_x = sd_sb.axis ? 16'd0 : c12_grad[0];
        c12_out.surf_norm_y = sd_sb.axis ? 16'd0 : c12_grad[1];
        c12_out.surf_norm_z = sd_sb.axis ? ONE_Q14 : c12_grad[2];
        c12_out.is_inside   = sd_sb.in_cap;
        c12_out.on_axis     = sd_sb.axis;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= c12_out;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    // a held result freezes the front of the pipeline too
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_v && !en) |=> r1_v)
        else $error("front stage lost an item during a stall");

    a_axis_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.on_axis) |-> (r_out.surf_norm_x == 16'sd0 &&
            r_out.surf_norm_y == 16'sd0 && r_out.surf_norm_z == $signed(ONE_Q14)))
        else $error("on-axis result without the up normal");

    a_inside_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.is_inside) |-> (r_out.signed_dist <= 32'sd0))
        else $error("inside flag with positive distance");

    a_grad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out.grad_x <= $signed(ONE_Q14) && r_out.grad_x >= -$signed(ONE_Q14) &&
                  r_out.grad_z <= $signed(ONE_Q14) && r_out.grad_z >= -$signed(ONE_Q14)))
        else $error("gradient component beyond unit range");

endmodule

`default_nettype wire
